// ----- hw/rtl/ifp_pkg.sv -----
`default_nettype none

package ifp_pkg;

    // default operator stack depth
    localparam int STACK_DEPTH = 32;

    typedef logic [7:0] t_sym;
    typedef logic [1:0] t_err;
    typedef logic [2:0] t_prec;

    // error codes carried on each result item
    localparam t_err ERR_OK       = 2'd0;
    localparam t_err ERR_OVERFLOW = 2'd1;
    localparam t_err ERR_CLOSE    = 2'd2;
    localparam t_err ERR_UNCLOSED = 2'd3;

    // ascii codes of the recognized characters
    localparam t_sym SYM_CARET   = 8'h5E;
    localparam t_sym SYM_STAR    = 8'h2A;
    localparam t_sym SYM_SLASH   = 8'h2F;
    localparam t_sym SYM_PERCENT = 8'h25;
    localparam t_sym SYM_PLUS    = 8'h2B;
    localparam t_sym SYM_MINUS   = 8'h2D;
    localparam t_sym SYM_LPAREN  = 8'h28;
    localparam t_sym SYM_LBRACE  = 8'h7B;
    localparam t_sym SYM_LBRACK  = 8'h5B;
    localparam t_sym SYM_RPAREN  = 8'h29;
    localparam t_sym SYM_RBRACE  = 8'h7D;
    localparam t_sym SYM_RBRACK  = 8'h5D;

    // precedence levels
    localparam t_prec PREC_NONE = 3'd0;
    localparam t_prec PREC_ADD  = 3'd4;
    localparam t_prec PREC_MUL  = 3'd5;
    localparam t_prec PREC_POW  = 3'd6;

    // source of an emitted symbol
    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_INPUT,
        SRC_TOP
    } t_src;

    // controller to datapath commands
    typedef struct packed {
        logic latch;
        logic emit;
        t_src src;
        t_err err;
        logic pop;
        logic clear;
        logic push;
        logic set_err3;
        logic finish;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic in_opnd;
        logic in_open;
        logic sym_end;
        logic sym_op;
        logic cnt_zero;
        logic cnt_full;
        logic top_marker;
        logic top_match;
        logic top_lower;
        logic err3;
        logic hold_v;
        logic out_free;
    } t_dp_stat;

    function automatic t_prec prec_of(input t_sym c);
        t_prec p;
        p = PREC_NONE;
        if (c == SYM_CARET) begin
            p = PREC_POW;
        end else if (c == SYM_STAR || c == SYM_SLASH || c == SYM_PERCENT) begin
            p = PREC_MUL;
        end else if (c == SYM_PLUS || c == SYM_MINUS) begin
            p = PREC_ADD;
        end
        return p;
    endfunction

    function automatic logic is_marker(input t_sym c);
        return (c == SYM_RPAREN) || (c == SYM_RBRACE) || (c == SYM_RBRACK);
    endfunction

    // closing marker for an opening bracket, zero otherwise
    function automatic t_sym closer_of(input t_sym c);
        t_sym m;
        m = '0;
        if (c == SYM_LPAREN) begin
            m = SYM_RPAREN;
        end else if (c == SYM_LBRACE) begin
            m = SYM_RBRACE;
        end else if (c == SYM_LBRACK) begin
            m = SYM_RBRACK;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ifp_if.sv -----
`default_nettype none

// input channel: one expression character per item
interface ifp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       end_of_expr;

    modport source (output valid, output symbol, output end_of_expr, input ready);
    modport sink   (input valid, input symbol, input end_of_expr, output ready);
endinterface

// output channel: one postfix result per item
interface ifp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_symbol;
    logic       has_symbol;
    logic       last;
    logic [1:0] error_code;

    modport source (output valid, output out_symbol, output has_symbol, output last,
                    output error_code, input ready);
    modport sink   (input valid, input out_symbol, input has_symbol, input last,
                    input error_code, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ifp_ram.sv -----
`default_nettype none

module ifp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/ifp_ctrl.sv -----
`default_nettype none

module ifp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire ifp_pkg::t_dp_stat i_stat,
    output ifp_pkg::t_dp_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOK   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_PUSH   = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic             w_can_emit;
    ifp_pkg::t_dp_cmd w_cmd;

    // an emit moves a held result out, so the output register must be free
    assign w_can_emit = !i_stat.hold_v || i_stat.out_free;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = w_cmd;

    // next state and commands
    always_comb begin
        w_cmd   = '0;
        w_cmd.src = ifp_pkg::SRC_NONE;
        w_cmd.err = ifp_pkg::ERR_OK;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.latch = 1'b1;
                    priority if (i_stat.in_opnd) begin
                        w_cmd.emit = 1'b1;
                        w_cmd.src  = ifp_pkg::SRC_INPUT;
                        n_state    = S_FIN;
                    end else if (i_stat.in_open) begin
                        n_state = S_PUSH;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if (i_stat.cnt_zero) begin
                    priority if (i_stat.sym_end) begin
                        if (w_can_emit) begin
                            w_cmd.emit = 1'b1;
                            w_cmd.err  = i_stat.err3 ? ifp_pkg::ERR_UNCLOSED : ifp_pkg::ERR_OK;
                            n_state    = S_FIN;
                        end
                    end else if (i_stat.sym_op) begin
                        n_state = S_PUSH;
                    end else begin
                        // closing bracket with nothing stacked
                        if (w_can_emit) begin
                            w_cmd.emit  = 1'b1;
                            w_cmd.err   = ifp_pkg::ERR_CLOSE;
                            w_cmd.clear = 1'b1;
                            n_state     = S_FIN;
                        end
                    end
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                priority if (i_stat.sym_end) begin
                    // flush: markers are dropped and flagged as unclosed
                    if (i_stat.top_marker) begin
                        w_cmd.pop      = 1'b1;
                        w_cmd.set_err3 = 1'b1;
                        n_state        = S_LOOK;
                    end else if (w_can_emit) begin
                        w_cmd.emit = 1'b1;
                        w_cmd.src  = ifp_pkg::SRC_TOP;
                        w_cmd.pop  = 1'b1;
                        n_state    = S_LOOK;
                    end
                end else if (i_stat.sym_op) begin
                    if (i_stat.top_marker || i_stat.top_lower) begin
                        n_state = S_PUSH;
                    end else if (w_can_emit) begin
                        w_cmd.emit = 1'b1;
                        w_cmd.src  = ifp_pkg::SRC_TOP;
                        w_cmd.pop  = 1'b1;
                        n_state    = S_LOOK;
                    end
                end else begin
                    // closing bracket
                    if (i_stat.top_marker) begin
                        if (i_stat.top_match) begin
                            w_cmd.pop = 1'b1;
                            n_state   = S_FIN;
                        end else if (w_can_emit) begin
                            w_cmd.emit  = 1'b1;
                            w_cmd.err   = ifp_pkg::ERR_CLOSE;
                            w_cmd.clear = 1'b1;
                            n_state     = S_FIN;
                        end
                    end else if (w_can_emit) begin
                        w_cmd.emit = 1'b1;
                        w_cmd.src  = ifp_pkg::SRC_TOP;
                        w_cmd.pop  = 1'b1;
                        n_state    = S_LOOK;
                    end
                end
            end
            S_PUSH: begin
                if (i_stat.cnt_full) begin
                    if (w_can_emit) begin
                        w_cmd.emit  = 1'b1;
                        w_cmd.err   = ifp_pkg::ERR_OVERFLOW;
                        w_cmd.clear = 1'b1;
                        n_state     = S_FIN;
                    end
                end else begin
                    w_cmd.push = 1'b1;
                    n_state    = S_FIN;
                end
            end
            S_FIN: begin
                // release the held result as the last one of this item
                if (!i_stat.hold_v) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    w_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ifp_dp.sv -----
`default_nettype none

module ifp_dp #(
    parameter int STACK_DEPTH = ifp_pkg::STACK_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [7:0]       i_symbol,
    input  wire logic             i_end_of_expr,
    input  wire ifp_pkg::t_dp_cmd i_cmd,
    output ifp_pkg::t_dp_stat     o_stat,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output logic [7:0]            o_out_symbol,
    output logic                  o_out_has_symbol,
    output logic                  o_out_last,
    output logic [1:0]            o_out_error_code
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [7:0]    r_sym;
    logic          r_end;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_err3;
    logic [7:0]    r_hold_sym;
    logic          r_hold_has;
    logic [1:0]    r_hold_err;
    logic          r_hold_v;
    logic [7:0]    r_out_sym;
    logic          r_out_has;
    logic          r_out_last;
    logic [1:0]    r_out_err;
    logic          r_out_valid;

    logic [CW-1:0] w_count_m1;
    logic [7:0]    w_top;
    logic [7:0]    w_push_val;
    logic [7:0]    w_closer;
    logic [7:0]    w_new_sym;
    logic          w_new_has;
    logic          w_move;
    logic          w_out_free;
    logic          w_in_op;
    logic          w_in_open;
    logic          w_in_close;

    // stack storage, read address follows the top of stack
    assign w_count_m1 = r_count - CW'(1);
    assign w_closer   = ifp_pkg::closer_of(r_sym);
    assign w_push_val = (w_closer != 8'd0) ? w_closer : r_sym;

    ifp_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_push_val),
        .i_raddr (w_count_m1[AW-1:0]),
        .o_rdata (w_top)
    );

    // classification of the incoming character
    assign w_in_op    = (ifp_pkg::prec_of(i_symbol) != ifp_pkg::PREC_NONE);
    assign w_in_open  = (ifp_pkg::closer_of(i_symbol) != 8'd0);
    assign w_in_close = ifp_pkg::is_marker(i_symbol);

    assign w_out_free = !r_out_valid || i_out_ready;

    // status toward the controller
    always_comb begin
        o_stat            = '0;
        o_stat.in_opnd    = !i_end_of_expr && !w_in_op && !w_in_open && !w_in_close;
        o_stat.in_open    = !i_end_of_expr && w_in_open;
        o_stat.sym_end    = r_end;
        o_stat.sym_op     = (ifp_pkg::prec_of(r_sym) != ifp_pkg::PREC_NONE);
        o_stat.cnt_zero   = (r_count == '0);
        o_stat.cnt_full   = (r_count == CW'(STACK_DEPTH));
        o_stat.top_marker = ifp_pkg::is_marker(w_top);
        o_stat.top_match  = (w_top == r_sym);
        o_stat.top_lower  = (ifp_pkg::prec_of(w_top) < ifp_pkg::prec_of(r_sym));
        o_stat.err3       = r_err3;
        o_stat.hold_v     = r_hold_v;
        o_stat.out_free   = w_out_free;
    end

    // symbol for a new result
    always_comb begin
        unique case (i_cmd.src)
            ifp_pkg::SRC_INPUT: begin
                w_new_sym = i_symbol;
                w_new_has = 1'b1;
            end
            ifp_pkg::SRC_TOP: begin
                w_new_sym = w_top;
                w_new_has = 1'b1;
            end
            default: begin
                w_new_sym = 8'd0;
                w_new_has = 1'b0;
            end
        endcase
    end

    // a held result leaves when another follows or the item finishes
    assign w_move = (i_cmd.emit && r_hold_v) || i_cmd.finish;

    // stack count
    always_comb begin
        n_count = r_count;
        priority if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.pop) begin
            n_count = w_count_m1;
        end else if (i_cmd.push) begin
            n_count = r_count + CW'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err3      <= 1'b0;
            r_hold_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.latch) begin
                r_err3 <= 1'b0;
            end else if (i_cmd.set_err3) begin
                r_err3 <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_hold_v <= 1'b1;
            end else if (i_cmd.finish) begin
                r_hold_v <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_sym <= i_symbol;
            r_end <= i_end_of_expr;
        end
        if (i_cmd.emit) begin
            r_hold_sym <= w_new_sym;
            r_hold_has <= w_new_has;
            r_hold_err <= i_cmd.err;
        end
        if (w_move) begin
            r_out_sym  <= r_hold_sym;
            r_out_has  <= r_hold_has;
            r_out_err  <= r_hold_err;
            r_out_last <= i_cmd.finish;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_symbol     = r_out_sym;
    assign o_out_has_symbol = r_out_has;
    assign o_out_last       = r_out_last;
    assign o_out_error_code = r_out_err;

endmodule

`default_nettype wire

// ----- hw/rtl/infix_to_postfix_converter.sv -----
// an operand result goes from the hold register to the output register when its item
//   finishes; a new item is accepted only in the idle state, after the previous one is
//   through; each popped entry needs a registered read of the stack top, and output
//   stalls hold the flow
// reset: synchronous active low; clears stack count, output and control state,
//   stack memory contents are left as they are (no clearing pass)
`default_nettype none

module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = ifp_pkg::STACK_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ifp_in_if.sink     i_in,
    ifp_out_if.source  o_out
);

    ifp_pkg::t_dp_cmd  w_cmd;
    ifp_pkg::t_dp_stat w_stat;

    // sequencing of pops, pushes and result release
    ifp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // stack, result hold and output register
    ifp_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_symbol         (i_in.symbol),
        .i_end_of_expr    (i_in.end_of_expr),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_out_symbol     (o_out.out_symbol),
        .o_out_has_symbol (o_out.has_symbol),
        .o_out_last       (o_out.last),
        .o_out_error_code (o_out.error_code)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/ifp_checker.sv -----
`default_nettype none

module ifp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_symbol,
    input wire logic       i_out_has_symbol,
    input wire logic       i_out_last,
    input wire logic [1:0] i_out_error_code
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_symbol)
            && $stable(i_out_has_symbol) && $stable(i_out_last)
            && $stable(i_out_error_code))
        else $error("stalled result changed");

    // a result without a symbol carries a zero symbol
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_has_symbol |-> i_out_symbol == 8'd0)
        else $error("empty result with nonzero symbol");

    // any error ends the item and never rides on a symbol
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_error_code != ifp_pkg::ERR_OK
            |-> i_out_last && !i_out_has_symbol)
        else $error("error result not final");

    // one item at a time: no acceptance right after an acceptance
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("back to back acceptance");

endmodule

bind infix_to_postfix_converter ifp_checker u_ifp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_symbol     (o_out.out_symbol),
    .i_out_has_symbol (o_out.has_symbol),
    .i_out_last       (o_out.last),
    .i_out_error_code (o_out.error_code)
);

`default_nettype wire

// ----- sim/ifp_postfix_checker.sv -----
module ifp_postfix_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_ready,
    input  wire logic [7:0] i_in_symbol,
    input  wire logic       i_in_end,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [7:0] i_out_symbol,
    input  wire logic       i_out_has,
    input  wire logic       i_out_last,
    input  wire logic [1:0] i_out_error,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_items_seen,
    output int              o_results_seen,
    output int              o_errors_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import ifp_pkg::*;

    // one postfix result item as the block should emit it
    typedef struct packed {
        t_sym sym;
        logic has;
        logic last;
        t_err err;
    } t_postfix_res;

    t_postfix_res pending_postfix[$];
    t_postfix_res item_postfix[$];

    // shadow of the operator stack
    t_sym shadow_ops [STACK_DEPTH];
    int   shadow_depth = 0;

    int fail_count    = 0;
    int items_seen    = 0;
    int results_seen  = 0;
    int errors_seen   = 0;

    // binding strength of an operator, zero for anything else
    function automatic int op_rank(input t_sym c);
        case (c)
            SYM_CARET:                        return int'(PREC_POW);
            SYM_STAR, SYM_SLASH, SYM_PERCENT: return int'(PREC_MUL);
            SYM_PLUS, SYM_MINUS:              return int'(PREC_ADD);
            default:                          return 0;
        endcase
    endfunction

    function automatic bit is_close_mark(input t_sym c);
        return (c == SYM_RPAREN) || (c == SYM_RBRACE) || (c == SYM_RBRACK);
    endfunction

    // marker pushed for an opening bracket
    function automatic t_sym mark_for_open(input t_sym c);
        case (c)
            SYM_LPAREN: return SYM_RPAREN;
            SYM_LBRACE: return SYM_RBRACE;
            SYM_LBRACK: return SYM_RBRACK;
            default:    return '0;
        endcase
    endfunction

    task automatic add_postfix(input t_sym s, input logic h, input t_err e);
        t_postfix_res r;
        r.sym  = s;
        r.has  = h;
        r.last = 1'b0;
        r.err  = e;
        item_postfix.push_back(r);
    endtask

    // push, or report overflow and drop the whole stack
    task automatic push_shadow(input t_sym c);
        if (shadow_depth >= STACK_DEPTH) begin
            shadow_depth = 0;
            add_postfix('0, 1'b0, ERR_OVERFLOW);
        end else begin
            shadow_ops[shadow_depth] = c;
            shadow_depth++;
        end
    endtask

    // work out the results one input item causes
    task automatic convert_symbol(input t_sym c, input logic eoe);
        t_sym         top;
        int           rank;
        bit           matched;
        t_err         e;
        t_postfix_res r;
        item_postfix.delete();
        if (eoe) begin
            // flush, markers are dropped and flagged
            e = ERR_OK;
            while (shadow_depth > 0) begin
                top = shadow_ops[shadow_depth - 1];
                shadow_depth--;
                if (is_close_mark(top)) begin
                    e = ERR_UNCLOSED;
                end else begin
                    add_postfix(top, 1'b1, ERR_OK);
                end
            end
            add_postfix('0, 1'b0, e);
        end else if (op_rank(c) > 0) begin
            // pop equal or stronger operators down to a marker
            rank = op_rank(c);
            while (shadow_depth > 0) begin
                top = shadow_ops[shadow_depth - 1];
                if (is_close_mark(top) || op_rank(top) < rank) break;
                shadow_depth--;
                add_postfix(top, 1'b1, ERR_OK);
            end
            push_shadow(c);
        end else if (mark_for_open(c) != '0) begin
            push_shadow(mark_for_open(c));
        end else if (is_close_mark(c)) begin
            // pop operators down to the matching marker
            matched = 1'b0;
            while (shadow_depth > 0) begin
                top = shadow_ops[shadow_depth - 1];
                if (is_close_mark(top)) begin
                    if (top == c) begin
                        shadow_depth--;
                        matched = 1'b1;
                    end
                    break;
                end
                shadow_depth--;
                add_postfix(top, 1'b1, ERR_OK);
            end
            if (!matched) begin
                shadow_depth = 0;
                add_postfix('0, 1'b0, ERR_CLOSE);
            end
        end else begin
            add_postfix(c, 1'b1, ERR_OK);
        end
        // flag the final result of the item
        foreach (item_postfix[i]) begin
            r = item_postfix[i];
            if (i == item_postfix.size() - 1) r.last = 1'b1;
            pending_postfix.push_back(r);
        end
    endtask

    // predict on input items, compare on result items
    always @(posedge i_clk) begin : watch
        t_postfix_res want;
        if (!i_rst_n) begin
            shadow_depth = 0;
            pending_postfix.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                convert_symbol(i_in_symbol, i_in_end);
                items_seen++;
            end
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (i_out_error != ERR_OK) errors_seen++;
                if (pending_postfix.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with nothing expected, got sym=%h has=%b last=%b err=%0d",
                             $time, i_out_symbol, i_out_has, i_out_last, i_out_error);
                end else begin
                    want = pending_postfix.pop_front();
                    if (i_out_symbol !== want.sym || i_out_has !== want.has ||
                        i_out_last !== want.last || i_out_error !== want.err) begin
                        fail_count++;
                        $display("%0t: result mismatch, expected sym=%h has=%b last=%b err=%0d",
                                 $time, want.sym, want.has, want.last, want.err);
                        $display("%0t:                   actual sym=%h has=%b last=%b err=%0d",
                                 $time, i_out_symbol, i_out_has, i_out_last, i_out_error);
                    end
                end
            end
        end
        o_fail_count   <= fail_count;
        o_pending      <= pending_postfix.size();
        o_items_seen   <= items_seen;
        o_results_seen <= results_seen;
        o_errors_seen  <= errors_seen;
    end

endmodule

// ----- sim/infix_to_postfix_converter_tb.sv -----
module infix_to_postfix_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ifp_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int DIRECTED_ITEMS = 27;
    localparam int RANDOM_ITEMS   = 325;
    localparam int LONG_HOLD      = 300;
    localparam int TAIL_CYCLES    = 100;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ifp_in_if  in_if ();
    ifp_out_if out_if ();

    int fail_count;
    int pending_cnt;
    int items_seen;
    int results_seen;
    int errors_seen;

    int items_sent    = 0;
    bit steady_flow   = 1'b0;
    bit stall_request = 1'b0;

    infix_to_postfix_converter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    ifp_postfix_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_if.valid),
        .i_in_ready     (in_if.ready),
        .i_in_symbol    (in_if.symbol),
        .i_in_end       (in_if.end_of_expr),
        .i_out_valid    (out_if.valid),
        .i_out_ready    (out_if.ready),
        .i_out_symbol   (out_if.out_symbol),
        .i_out_has      (out_if.has_symbol),
        .i_out_last     (out_if.last),
        .i_out_error    (out_if.error_code),
        .o_fail_count   (fail_count),
        .o_pending      (pending_cnt),
        .o_items_seen   (items_seen),
        .o_results_seen (results_seen),
        .o_errors_seen  (errors_seen)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_sym bracket_open(input int k);
        case (k)
            0:       return SYM_LPAREN;
            1:       return SYM_LBRACE;
            default: return SYM_LBRACK;
        endcase
    endfunction

    function automatic t_sym bracket_close(input int k);
        case (k)
            0:       return SYM_RPAREN;
            1:       return SYM_RBRACE;
            default: return SYM_RBRACK;
        endcase
    endfunction

    function automatic t_sym pick_operator();
        case ($urandom_range(0, 5))
            0:       return SYM_CARET;
            1:       return SYM_STAR;
            2:       return SYM_SLASH;
            3:       return SYM_PERCENT;
            4:       return SYM_PLUS;
            default: return SYM_MINUS;
        endcase
    endfunction

    // letters and digits mostly, any byte now and then
    function automatic t_sym pick_operand();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return t_sym'($urandom_range(8'h61, 8'h7A));
        if (r < 80) return t_sym'($urandom_range(8'h30, 8'h39));
        return t_sym'($urandom_range(0, 255));
    endfunction

    // offer one item and hold it until accepted
    task automatic send_sym(input t_sym s, input logic eoe);
        int gap;
        gap = steady_flow ? 0 : pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.symbol      <= s;
        in_if.end_of_expr <= eoe;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic send_end();
        send_sym(t_sym'($urandom_range(0, 255)), 1'b1);
    endtask

    // stop offering and wait for every expected result
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_cnt != 0);
    endtask

    // more pushes than the stack holds, then an end item
    task automatic send_overflow();
        int  n;
        bit  after_open;
        n = $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4);
        after_open = 1'b0;
        repeat (n) begin
            if (after_open && $urandom_range(0, 99) < 40) begin
                send_sym(pick_operator(), 1'b0);
                after_open = 1'b0;
            end else begin
                send_sym(bracket_open($urandom_range(0, 2)), 1'b0);
                after_open = 1'b1;
            end
        end
        send_end();
    endtask

    // well-formed expression with random content, some of them broken
    task automatic send_expression(input bit long_one);
        int   tokens;
        int   k;
        bit   want_operand;
        bit   noisy;
        t_sym c;
        t_sym closers[$];
        tokens       = long_one ? $urandom_range(40, 60) : $urandom_range(1, 20);
        noisy        = ($urandom_range(0, 99) < 20);
        want_operand = 1'b1;
        for (k = 0; k < tokens; k++) begin
            if (noisy && $urandom_range(0, 9) == 0) begin
                send_sym(t_sym'($urandom_range(0, 255)), 1'b0);
            end
            if (want_operand) begin
                if (closers.size() < 12 && $urandom_range(0, 99) < 30) begin
                    c = t_sym'($urandom_range(0, 2));
                    send_sym(bracket_open(int'(c)), 1'b0);
                    closers.push_back(bracket_close(int'(c)));
                end else begin
                    send_sym(pick_operand(), 1'b0);
                    want_operand = 1'b0;
                end
            end else if (closers.size() > 0 && $urandom_range(0, 99) < 35) begin
                send_sym(closers.pop_back(), 1'b0);
            end else begin
                send_sym(pick_operator(), 1'b0);
                want_operand = 1'b1;
            end
        end
        if (want_operand) send_sym(pick_operand(), 1'b0);
        // close what is open, a broken one may leave, swap or add a bracket
        while (closers.size() > 0) begin
            if (noisy && $urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 2))
                    0: closers.delete();
                    1: begin
                        c = closers.pop_back();
                        send_sym((c == SYM_RPAREN) ? SYM_RBRACE : SYM_RPAREN, 1'b0);
                    end
                    default: send_sym(bracket_close($urandom_range(0, 2)), 1'b0);
                endcase
            end else begin
                send_sym(closers.pop_back(), 1'b0);
            end
        end
        if (noisy && $urandom_range(0, 3) == 0) begin
            send_sym(bracket_close($urandom_range(0, 2)), 1'b0);
        end
        send_end();
    endtask

    // one random burst: expression, noise or overflow
    task automatic send_burst(input bit long_one);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            send_overflow();
        end else if (r < 12) begin
            repeat ($urandom_range(1, 4)) begin
                send_sym(t_sym'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end else begin
            send_expression(long_one);
        end
    endtask

    // result side pacing, with one long hold on request
    initial begin : out_pacing
        int run;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (stall_request) begin
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                stall_request = 1'b0;
            end else if (steady_flow) begin
                out_if.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                run = pick_gap();
                if (run > 0) begin
                    out_if.ready <= 1'b0;
                    repeat (run) @(posedge i_clk);
                end
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // run limit
    initial begin
        #50_000_000;
        $display("** infix_to_postfix_converter: FAILED **");
        $finish;
    end

    // stimulus and verdict
    initial begin
        in_if.valid       <= 1'b0;
        in_if.symbol      <= '0;
        in_if.end_of_expr <= 1'b0;
        i_rst_n           <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every bracket kind and every operator but plus in one expression
        send_sym(SYM_LPAREN, 1'b0);
        send_sym("a", 1'b0);
        send_sym(SYM_PERCENT, 1'b0);
        send_sym("b", 1'b0);
        send_sym(SYM_RPAREN, 1'b0);
        send_sym(SYM_SLASH, 1'b0);
        send_sym(SYM_LBRACE, 1'b0);
        send_sym("c", 1'b0);
        send_sym(SYM_CARET, 1'b0);
        send_sym("d", 1'b0);
        send_sym(SYM_RBRACE, 1'b0);
        send_sym(SYM_MINUS, 1'b0);
        send_sym(SYM_LBRACK, 1'b0);
        send_sym("e", 1'b0);
        send_sym(SYM_STAR, 1'b0);
        send_sym("f", 1'b0);
        send_sym(SYM_RBRACK, 1'b0);
        send_sym(8'hFF, 1'b1);
        // close with nothing open
        send_sym(SYM_RBRACK, 1'b0);
        // close of the wrong kind after a pending operator, extreme operand
        send_sym(SYM_LBRACK, 1'b0);
        send_sym(8'hFF, 1'b0);
        send_sym(SYM_PLUS, 1'b0);
        send_sym("y", 1'b0);
        send_sym(SYM_RBRACE, 1'b0);
        // bracket left open at end, zero operand
        send_sym(SYM_LBRACE, 1'b0);
        send_sym(8'h00, 1'b0);
        send_sym(8'h00, 1'b1);

        send_overflow();
        while (items_sent < DIRECTED_ITEMS + 120) send_burst(1'b0);

        // hold the result side while input keeps coming
        stall_request = 1'b1;
        send_expression(1'b1);
        send_expression(1'b1);
        while (items_sent < DIRECTED_ITEMS + 190) send_burst(1'b0);

        // full drain, then a stretch with no idling
        wait_drained();
        steady_flow = 1'b1;
        while (items_sent < DIRECTED_ITEMS + 250) send_burst($urandom_range(0, 4) == 0);
        steady_flow = 1'b0;
        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) send_burst($urandom_range(0, 9) == 0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d input items, %0d postfix results, %0d of them error results",
                 items_seen, results_seen, errors_seen);
        $display("incl. all bracket kinds, overflow bursts, a long output hold and a drain pause");
        if (fail_count == 0) begin
            $display("** infix_to_postfix_converter: PASSED **");
        end else begin
            $display("** infix_to_postfix_converter: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/ifp_pkg.sv
hw/rtl/ifp_if.sv
hw/rtl/ifp_ram.sv
hw/rtl/ifp_ctrl.sv
hw/rtl/ifp_dp.sv
hw/rtl/infix_to_postfix_converter.sv
hw/rtl/ifp_checker.sv
sim/ifp_postfix_checker.sv
sim/infix_to_postfix_converter_tb.sv
